>>> rtl/simplex_noise_3d_assert.svh
// Assertion macros used by the simplex noise checker.
`ifndef SIMPLEX_NOISE_3D_ASSERT_SVH
`define SIMPLEX_NOISE_3D_ASSERT_SVH

// Same-cycle implication, gated off during reset.
`define SNZ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated off during reset.
`define SNZ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define SNZ_ASSERT_NXT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/snz_pkg.sv
// Shared constants, tables and helper functions for the 3D simplex noise pipeline.
package snz_pkg;

    localparam int COORD_FRAC_BITS_DEF = 16;
    localparam int OUT_FRAC_BITS_DEF   = 14;

    localparam int WORK_FRAC = 28;
    localparam logic [WORK_FRAC-1:0] CLIP_Q28 = 28'd161061274;

    // corner offset width (Q.28, signed), square width and corner term width
    localparam int DW  = 30;
    localparam int SQW = 57;
    localparam int TW  = 61;

    localparam int HASH_W = 8;
    localparam int GSEL_W = 4;

    localparam logic [1:0] G_Z = 2'b00;
    localparam logic [1:0] G_P = 2'b01;
    localparam logic [1:0] G_N = 2'b11;

    // gradient entries packed {gz, gy, gx}
    localparam logic [5:0] GRAD [16] = '{
        {G_Z, G_P, G_P}, {G_Z, G_P, G_N}, {G_Z, G_N, G_P}, {G_Z, G_N, G_N},
        {G_P, G_Z, G_P}, {G_P, G_Z, G_N}, {G_N, G_Z, G_P}, {G_N, G_Z, G_N},
        {G_P, G_P, G_Z}, {G_P, G_N, G_Z}, {G_N, G_P, G_Z}, {G_N, G_N, G_Z},
        6'b0, 6'b0, 6'b0, 6'b0
    };

    localparam logic [7:0] PERM [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    // floor(n / 3) for any 32-bit unsigned n, by reciprocal multiply
    function automatic logic [30:0] div3(input logic [31:0] n);
        logic [63:0] p;
        p = 64'(n) * 64'h0000_0000_AAAA_AAAB;
        return p[63:33];
    endfunction

    function automatic logic [GSEL_W-1:0] mod12(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if (r >= 8'd192) r = r - 8'd192;
        if (r >= 8'd96)  r = r - 8'd96;
        if (r >= 8'd48)  r = r - 8'd48;
        if (r >= 8'd24)  r = r - 8'd24;
        if (r >= 8'd12)  r = r - 8'd12;
        return r[GSEL_W-1:0];
    endfunction

    function automatic logic signed [DW+1:0] gpick(input logic [1:0] code,
                                                   input logic signed [DW-1:0] d);
        logic signed [DW+1:0] e;
        e = (DW+2)'(d);
        unique case (code)
            G_P:     return e;
            G_N:     return -e;
            default: return '0;
        endcase
    endfunction

endpackage

>>> rtl/simplex_noise_3d.sv
// 3D simplex noise evaluator, fully pipelined, one point per beat.
//
// Input channel (s_): one beat carries a point as three signed fixed-point
// coordinates with COORD_FRAC_BITS fraction bits, x in the low word.
// Output channel (m_): one beat per input beat, in order, carrying the noise
// value as signed 16 bits with OUT_FRAC_BITS fraction bits, saturated.
// Throughput is one point per cycle while m_tready is high: eleven register
// stages (skew/floor, divide by three, corner setup and first hash, offset
// scaling, squares and final hash, clip and dot product, t^2, t^4, corner
// term, corner sum, round/saturate) with the four corners computed in
// parallel units.
// Each stage holds a valid bit; a stage loads whenever it is empty or the
// next stage moves, so bubbles collapse and s_tready stays high while any
// stage is free. When m_tready is held low the pipeline fills and then
// s_tready drops; nothing is lost or repeated and m_tdata holds.
// Reset (aresetn low at a clock edge) clears all valid bits; in-flight
// points are dropped. There is no configuration or stored state.
module simplex_noise_3d
    import snz_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS   = OUT_FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // x_coord[31:0], y_coord[63:32], z_coord[95:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // noise_value[15:0]
);

    localparam int F       = COORD_FRAC_BITS;
    localparam int NW      = 35 - F;
    localparam int AW      = F + 5;
    localparam int SH      = 51 - OUT_FRAC_BITS;
    localparam int NUM_STG = 11;
    localparam int ACCW    = 63;
    localparam logic [34:0]     BIAS1   = 35'(3) << (NW - 1);
    localparam logic [30:0]     CI_BIAS = 31'(1) << (NW - 1);
    localparam logic [AW-1:0]   U1      = AW'(1) << F;
    localparam logic [AW-1:0]   U6      = AW'(6) << F;
    localparam logic signed [ACCW-1:0] HALF   = ACCW'(1) << (SH - 1);
    localparam logic signed [ACCW-1:0] SAT_HI = ACCW'(32767);
    localparam logic signed [ACCW-1:0] SAT_LO = ~SAT_HI;

    logic [NUM_STG:1] v_reg, en;

    logic [31:0]        coord [3];
    logic [31:0]        m1_reg [3], m1_next [3];
    logic [AW-1:0]      xl1_reg [3], xl2_reg [3];
    logic [HASH_W-1:0]  c2_reg [3], c2_next [3];
    logic [31:0]        m3_reg [4][3], m3_next [4][3];
    logic [HASH_W-1:0]  hi3_reg [4], hj3_reg [4], hi3_next [4], hj3_next [4];
    logic [HASH_W-1:0]  pa_reg [4], pa_next [4];
    logic [HASH_W-1:0]  hi4_reg [4], pb_reg [4], pb_next [4];
    logic [GSEL_W-1:0]  g_reg [4], g_next [4];
    logic signed [TW-1:0]   term [4];
    logic signed [ACCW-1:0] acc_reg, acc_next, rv;
    logic [15:0]        out_reg, out_next;

    logic signed [34:0] e [3];
    logic signed [34:0] n, fm;
    logic [AW-1:0]      ce [3], a6, c6, cs;
    logic [AW-1:0]      av [3];
    logic [AW-1:0]      o;
    logic signed [31:0] oe;
    logic [2:0]         s1, s2, sc;
    logic [1:0]         cmul;
    logic [HASH_W-1:0]  ck_h;

    assign coord[0] = s_tdata[31:0];
    assign coord[1] = s_tdata[63:32];
    assign coord[2] = s_tdata[95:64];

    // handshake: a stage loads when empty or when its successor moves
    always_comb begin
        en[NUM_STG] = !v_reg[NUM_STG] || m_tready;
        for (int k = NUM_STG - 1; k >= 1; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[1]) v_reg[1] <= s_tvalid;
            for (int k = 2; k <= NUM_STG; k++) begin
                if (en[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // stage 1: skew, floor by 2^F, bias positive
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            e[a] = 35'($signed(coord[a]));
        end
        for (int a = 0; a < 3; a++) begin
            n          = (e[a] <<< 2) + e[(a+1)%3] + e[(a+2)%3];
            fm         = n >>> F;
            m1_next[a] = 32'(fm + BIAS1);
        end
    end

    // stage 2: cell index mod 256
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            c2_next[a] = HASH_W'(div3(m1_reg[a]) - CI_BIAS);
        end
    end

    // stage 3: unskew, order, corner offsets, first hash lookup
    always_comb begin
        cs = '0;
        for (int a = 0; a < 3; a++) begin
            ce[a] = AW'(c2_reg[a]);
            cs    = cs + (ce[a] << F);
        end
        for (int a = 0; a < 3; a++) begin
            a6    = AW'(xl2_reg[a] * AW'(6));
            c6    = AW'(ce[a] * AW'(6)) << F;
            av[a] = a6 - c6 + cs;
        end
        // s1/s2 = {k, j, i} increments of the second and third corners
        if ($signed(av[0]) >= $signed(av[1])) begin
            if ($signed(av[1]) >= $signed(av[2])) begin
                s1 = 3'b001; s2 = 3'b011;
            end else if ($signed(av[0]) >= $signed(av[2])) begin
                s1 = 3'b001; s2 = 3'b101;
            end else begin
                s1 = 3'b100; s2 = 3'b101;
            end
        end else begin
            if ($signed(av[1]) < $signed(av[2])) begin
                s1 = 3'b100; s2 = 3'b110;
            end else if ($signed(av[0]) < $signed(av[2])) begin
                s1 = 3'b010; s2 = 3'b110;
            end else begin
                s1 = 3'b010; s2 = 3'b011;
            end
        end
        for (int c = 0; c < 4; c++) begin
            unique case (c)
                0:       sc = 3'b000;
                1:       sc = s1;
                2:       sc = s2;
                default: sc = 3'b111;
            endcase
            cmul = 2'(c);
            for (int a = 0; a < 3; a++) begin
                o  = av[a] - (sc[a] ? U6 : '0) + AW'(U1 * AW'(cmul));
                oe = 32'($signed(o));
                m3_next[c][a] = 32'(oe <<< (27 - F)) + 32'hC000_0000;
            end
            hi3_next[c] = c2_reg[0] + HASH_W'(sc[0]);
            hj3_next[c] = c2_reg[1] + HASH_W'(sc[1]);
            ck_h        = c2_reg[2] + HASH_W'(sc[2]);
            pa_next[c]  = PERM[ck_h];
        end
    end

    // stages 4 and 5: remaining hash lookups
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            pb_next[c] = PERM[hj3_reg[c] + pa_reg[c]];
            g_next[c]  = mod12(PERM[hi4_reg[c] + pb_reg[c]]);
        end
    end

    // stage 10 and 11: corner sum, round half up, saturate
    always_comb begin
        acc_next = ACCW'(term[0]) + ACCW'(term[1]) + ACCW'(term[2]) + ACCW'(term[3]);
        rv       = (acc_reg + HALF) >>> SH;
        if (rv > SAT_HI) begin
            out_next = SAT_HI[15:0];
        end else if (rv < SAT_LO) begin
            out_next = SAT_LO[15:0];
        end else begin
            out_next = rv[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            m1_reg <= m1_next;
            for (int a = 0; a < 3; a++) begin
                xl1_reg[a] <= coord[a][AW-1:0];
            end
        end
        if (en[2]) begin
            c2_reg  <= c2_next;
            xl2_reg <= xl1_reg;
        end
        if (en[3]) begin
            m3_reg  <= m3_next;
            hi3_reg <= hi3_next;
            hj3_reg <= hj3_next;
            pa_reg  <= pa_next;
        end
        if (en[4]) begin
            pb_reg  <= pb_next;
            hi4_reg <= hi3_reg;
        end
        if (en[5]) begin
            g_reg <= g_next;
        end
        if (en[10]) begin
            acc_reg <= acc_next;
        end
        if (en[11]) begin
            out_reg <= out_next;
        end
    end

    for (genvar c = 0; c < 4; c++) begin : g_corner
        snz_corner u_corner (
            .aclk     (aclk),
            .stage_en (en[9:4]),
            .ofs_x    (m3_reg[c][0]),
            .ofs_y    (m3_reg[c][1]),
            .ofs_z    (m3_reg[c][2]),
            .grad_sel (g_reg[c]),
            .term     (term[c])
        );
    end

    assign s_tready = en[1];
    assign m_tvalid = v_reg[NUM_STG];
    assign m_tdata  = out_reg;

endmodule

>>> rtl/snz_corner.sv
// One tetrahedron corner: offset scaling, r^2 clip, falloff power and gradient term.
module snz_corner
    import snz_pkg::*;
(
    input  logic                    aclk,
    input  logic [5:0]              stage_en,
    input  logic [31:0]             ofs_x,
    input  logic [31:0]             ofs_y,
    input  logic [31:0]             ofs_z,
    input  logic [GSEL_W-1:0]       grad_sel,
    output logic signed [TW-1:0]    term
);

    logic signed [DW-1:0]     d_reg [3];
    logic signed [DW-1:0]     d_next [3];
    logic signed [DW-1:0]     d5_reg [3];
    logic [SQW-1:0]           sq_reg [3];
    logic [SQW-1:0]           sq_next [3];
    logic [WORK_FRAC-1:0]     t_reg, t_next;
    logic [WORK_FRAC-1:0]     t2_reg, t2_next;
    logic [WORK_FRAC-1:0]     t4_reg, t4_next;
    logic signed [DW+1:0]     dp_reg, dp_next, dp7_reg, dp8_reg;
    logic signed [TW-1:0]     term_reg, term_next;
    logic [SQW+1:0]           ssum;
    logic [SQW+1-WORK_FRAC:0] r2;
    logic [2*WORK_FRAC-1:0]   tt, t2t2;
    logic [31:0]              ofs [3];
    logic [30:0]              q [3];
    logic signed [2*DW-1:0]   prod [3];
    logic [5:0]               gv;

    assign ofs[0] = ofs_x;
    assign ofs[1] = ofs_y;
    assign ofs[2] = ofs_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            q[a]       = div3(ofs[a]);
            d_next[a]  = DW'(q[a] - 31'h4000_0000);
            prod[a]    = d_reg[a] * d_reg[a];
            sq_next[a] = SQW'(prod[a]);
        end
    end

    always_comb begin
        ssum   = (SQW+2)'(sq_reg[0]) + (SQW+2)'(sq_reg[1]) + (SQW+2)'(sq_reg[2]);
        r2     = ssum[SQW+1:WORK_FRAC];
        t_next = (r2 < (SQW+2-WORK_FRAC)'(CLIP_Q28)) ? WORK_FRAC'(CLIP_Q28 - r2) : '0;
        gv     = GRAD[grad_sel];
        dp_next = gpick(gv[1:0], d5_reg[0]) + gpick(gv[3:2], d5_reg[1])
                + gpick(gv[5:4], d5_reg[2]);
        tt        = (2*WORK_FRAC)'(t_reg) * (2*WORK_FRAC)'(t_reg);
        t2_next   = tt[2*WORK_FRAC-1:WORK_FRAC];
        t2t2      = (2*WORK_FRAC)'(t2_reg) * (2*WORK_FRAC)'(t2_reg);
        t4_next   = t2t2[2*WORK_FRAC-1:WORK_FRAC];
        term_next = $signed({1'b0, t4_reg}) * dp8_reg;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            d_reg <= d_next;
        end
        if (stage_en[1]) begin
            sq_reg <= sq_next;
            d5_reg <= d_reg;
        end
        if (stage_en[2]) begin
            t_reg  <= t_next;
            dp_reg <= dp_next;
        end
        if (stage_en[3]) begin
            t2_reg  <= t2_next;
            dp7_reg <= dp_reg;
        end
        if (stage_en[4]) begin
            t4_reg  <= t4_next;
            dp8_reg <= dp7_reg;
        end
        if (stage_en[5]) begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule

>>> rtl/snz_checker.sv
// Port-level checks for the simplex noise pipeline, bound to the top level.
`include "simplex_noise_3d_assert.svh"

module snz_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    `SNZ_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "output beat dropped")
    `SNZ_ASSERT_NXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "stalled data moved")
    `SNZ_ASSERT_IMP(a_no_back_stall, m_tready, s_tready, "input stalled while output drains")
    `SNZ_ASSERT_NXT_RST(a_reset_empty, !aresetn, !m_tvalid, "output valid after reset")

endmodule

bind simplex_noise_3d snz_checker u_snz_checker (.*);

>>> verif/simplex_noise_3d_tb.sv
// Stream testbench for simplex_noise_3d with a built-in noise predictor.
module simplex_noise_3d_tb
    import snz_pkg::*;
();

    localparam int CFB = COORD_FRAC_BITS_DEF;
    localparam int OFB = OUT_FRAC_BITS_DEF;
    localparam int N_RANDOM = 1330;
    localparam int IDLE_LIMIT = 5000;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        bit                 known;
        logic signed [15:0] noise;
    } point_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    logic signed [15:0] noise_due[$];
    int errors;
    int beats_out;
    int idle_cycles;
    bit sending_done;
    bit hold_off;
    point_row_t corner_rows[$];

    simplex_noise_3d uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q--;
        return q;
    endfunction

    function automatic int grad_index(longint ci, longint cj, longint ck);
        logic [7:0] h;
        h = PERM[8'(ck)];
        h = PERM[8'(cj + h)];
        h = PERM[8'(ci + h)];
        return h % 12;
    endfunction

    function automatic longint corner_contrib(longint nx, longint ny, longint nz, int g);
        longint dx, dy, dz, r2, t, t2, t4, dp;
        int gx[12] = '{1, -1, 1, -1, 1, -1, 1, -1, 0, 0, 0, 0};
        int gy[12] = '{1, 1, -1, -1, 0, 0, 0, 0, 1, -1, 1, -1};
        int gz[12] = '{0, 0, 0, 0, 1, 1, -1, -1, 1, 1, -1, -1};
        dx = floor_div(nx * (64'sd1 << WORK_FRAC), 64'sd6 << CFB);
        dy = floor_div(ny * (64'sd1 << WORK_FRAC), 64'sd6 << CFB);
        dz = floor_div(nz * (64'sd1 << WORK_FRAC), 64'sd6 << CFB);
        r2 = (dx * dx + dy * dy + dz * dz) >>> WORK_FRAC;
        t = longint'(CLIP_Q28) - r2;
        if (t <= 0) return 0;
        t2 = (t * t) >>> WORK_FRAC;
        t4 = (t2 * t2) >>> WORK_FRAC;
        dp = gx[g] * dx + gy[g] * dy + gz[g] * dz;
        return t4 * dp;
    endfunction

    function automatic logic signed [15:0] noise_at(logic signed [31:0] px,
                                                    logic signed [31:0] py,
                                                    logic signed [31:0] pz);
        longint u, x, y, z, s, ci, cj, ck, cs, ax, ay, az, acc, v;
        int i1, j1, k1, i2, j2, k2, sh;
        u = 64'sd1 << CFB;
        x = px; y = py; z = pz;
        s = x + y + z;
        ci = floor_div(3 * x + s, 3 * u);
        cj = floor_div(3 * y + s, 3 * u);
        ck = floor_div(3 * z + s, 3 * u);
        cs = (ci + cj + ck) * u;
        ax = 6 * x - 6 * ci * u + cs;
        ay = 6 * y - 6 * cj * u + cs;
        az = 6 * z - 6 * ck * u + cs;
        if (ax >= ay) begin
            if (ay >= az) begin i1 = 1; j1 = 0; k1 = 0; i2 = 1; j2 = 1; k2 = 0; end
            else if (ax >= az) begin i1 = 1; j1 = 0; k1 = 0; i2 = 1; j2 = 0; k2 = 1; end
            else begin i1 = 0; j1 = 0; k1 = 1; i2 = 1; j2 = 0; k2 = 1; end
        end else begin
            if (ay < az) begin i1 = 0; j1 = 0; k1 = 1; i2 = 0; j2 = 1; k2 = 1; end
            else if (ax < az) begin i1 = 0; j1 = 1; k1 = 0; i2 = 0; j2 = 1; k2 = 1; end
            else begin i1 = 0; j1 = 1; k1 = 0; i2 = 1; j2 = 1; k2 = 0; end
        end
        acc = corner_contrib(ax, ay, az, grad_index(ci, cj, ck));
        acc += corner_contrib(ax - 6 * i1 * u + u, ay - 6 * j1 * u + u,
                              az - 6 * k1 * u + u, grad_index(ci + i1, cj + j1, ck + k1));
        acc += corner_contrib(ax - 6 * i2 * u + 2 * u, ay - 6 * j2 * u + 2 * u,
                              az - 6 * k2 * u + 2 * u, grad_index(ci + i2, cj + j2, ck + k2));
        acc += corner_contrib(ax - 3 * u, ay - 3 * u, az - 3 * u,
                              grad_index(ci + 1, cj + 1, ck + 1));
        sh = 51 - OFB;
        v = floor_div(acc + (64'sd1 << (sh - 1)), 64'sd1 << sh);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("MISMATCH beat %0d %s: got %0d want %0d", beats_out, what,
                 $signed(got), $signed(want));
        errors++;
    endtask

    task automatic add_row(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           bit known = 0, logic [15:0] noise = 0);
        point_row_t r;
        r.x = x; r.y = y; r.z = z; r.known = known; r.noise = noise;
        corner_rows.push_back(r);
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        noise_due.push_back(noise_at(x, y, z));
    endtask

    task automatic send_gap();
        int g;
        g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(0, 20 << CFB)) - (10 << CFB));
            2:       return 32'({8'($urandom_range(0, 255)), 16'h0000})
                            + 32'($urandom_range(0, 1) << 24);
            default: return 32'($signed($urandom_range(0, 4096 << CFB)) - (2048 << CFB));
        endcase
    endfunction

    // output side: check, stall pattern, long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                beats_out++;
                if (noise_due.size() == 0) begin
                    report_mismatch("unexpected beat", m_tdata, 16'h0);
                end else begin
                    logic [15:0] want;
                    want = noise_due.pop_front();
                    if (m_tdata !== want) report_mismatch("noise_value", m_tdata, want);
                end
            end
            m_tready <= !hold_off && (beats_out % 200 < 60 || $urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
                $display("simplex_noise_3d test failed");
                $finish;
            end
        end
    end

    initial begin
        hold_off = 1'b0;
        wait (sending_done == 0 && aresetn);
        repeat (300) @(posedge aclk);
        hold_off = 1'b1;
        repeat (80) @(posedge aclk);
        hold_off = 1'b0;
    end

    initial begin
        errors = 0; beats_out = 0; sending_done = 0;
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_row(32'h0, 32'h0, 32'h0, 1, 16'sd0);
        add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_row(32'h0000_0001, 32'h0000_0002, 32'h0000_0003);
        add_row(32'h0001_0000, 32'h0, 32'h0);
        add_row(32'h0, 32'h0001_0000, 32'h0);
        add_row(32'h0, 32'h0, 32'h0001_0000);
        add_row(32'h0000_8000, 32'h0000_4000, 32'h0000_C000);
        add_row(32'h0100_8000, 32'h0000_4000, 32'h0000_C000); // wraps after 256 cells
        add_row(32'h0000_8000, 32'h0100_4000, 32'h0200_C000);
        add_row(32'h0000_5555, 32'h0000_5555, 32'h0000_5555);
        add_row(32'h0000_4000, 32'h0000_C000, 32'h0000_8000);
        add_row(32'h0000_C000, 32'h0000_8000, 32'h0000_4000);
        add_row(32'h0000_4000, 32'h0000_8000, 32'h0000_C000);
        add_row(32'hFFFF_8000, 32'h0000_3000, 32'hFFFE_2000);
        add_row(32'h0012_3456, 32'hFFED_CBA9, 32'h0BAD_F00D);
        add_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333);

        foreach (corner_rows[i]) begin
            if (corner_rows[i].known && noise_at(corner_rows[i].x, corner_rows[i].y,
                                                 corner_rows[i].z) !== corner_rows[i].noise)
                report_mismatch("predictor row", noise_at(corner_rows[i].x,
                                corner_rows[i].y, corner_rows[i].z), corner_rows[i].noise);
            send_point(corner_rows[i].x, corner_rows[i].y, corner_rows[i].z);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            send_point(rand_coord(), rand_coord(), rand_coord());
            if (n % 64 >= 16) send_gap();
        end
        s_tvalid <= 1'b0;
        sending_done = 1;

        while (noise_due.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);

        $display("covered %0d points: zero, range ends, cell wrap, all six corner orders,",
                 beats_out);
        $display("random points with bursty input, output stalls and a full-pipeline stall");
        if (errors == 0) begin
            $display("simplex_noise_3d test passed");
        end else begin
            $display("simplex_noise_3d test failed");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+rtl
rtl/snz_pkg.sv
rtl/snz_corner.sv
rtl/simplex_noise_3d.sv
rtl/snz_checker.sv
verif/simplex_noise_3d_tb.sv
